/* rtl/tcmesi_pkg.sv */
package tcmesi_pkg;

    localparam int MAX_SETS_DEF   = 256;
    localparam int WAYS_DEF       = 8;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Width of the shared remainder unit.
    localparam int REM_W = 16;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic       COHERENT_RST = 1'b1;
    localparam logic [4:0] OFFSET_RST   = 5'd5;
    localparam logic [3:0] INDEX_RST    = 4'd8;
    localparam logic [3:0] WAYS_RST     = 4'd8;
    localparam logic [15:0] SEED_RST    = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COHERENT = 3'd0,
        CFG_OFFSET   = 3'd1,
        CFG_INDEX    = 3'd2,
        CFG_WAYS     = 3'd3,
        CFG_SEED     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LS_I = 2'd0,
        LS_S = 2'd1,
        LS_E = 2'd2,
        LS_M = 2'd3
    } line_st_t;

    typedef struct packed {
        logic        command;
        logic        requester;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  requester_state;
        logic [1:0]  peer_state;
        logic [2:0]  way_used;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } res_t;

endpackage

/* rtl/tcmesi_rem.sv */
module tcmesi_rem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tcmesi_pkg::REM_W-1:0] dividend,
    input  logic [tcmesi_pkg::REM_W-1:0] divisor,
    output logic                        done,
    output logic [tcmesi_pkg::REM_W-1:0] remainder
);

    localparam int W = tcmesi_pkg::REM_W;

    logic         active_reg;
    logic [1:0]   cnt_reg;
    logic         done_reg;
    logic [W-1:0] shift_reg;
    logic [W-1:0] div_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;

    // Four restoring steps per cycle, most significant dividend bits first.
    function automatic logic [W-1:0] step4(logic [W-1:0] r, logic [3:0] bits,
                                           logic [W-1:0] d);
        logic [W:0]   t;
        logic [W-1:0] acc;
        acc = r;
        for (int k = 3; k >= 0; k--)
        begin
            t = {acc, bits[k]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            acc = t[W-1:0];
        end
        return acc;
    endfunction

    assign rem_next  = step4(rem_reg, shift_reg[W-1 -: 4], div_reg);
    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (active_reg)
        begin
            shift_reg <= {shift_reg[W-5:0], 4'd0};
            rem_reg   <= rem_next;
        end
    end

    as_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !start)
        else $error("remainder unit restarted while working");

endmodule

/* rtl/two_cache_mesi_coherence_core.sv */
// Channel  | Direction | Handshake                      | Payload
// request  | in        | start & !busy                  | request (req_t)
// result   | out       | done, one cycle, no backpress. | result (res_t)
// config   | in        | cfg_valid & cfg_ready          | cfg_index, cfg_data
//
// The set index is reduced modulo MAX_SETS by a reciprocal multiply at accept
// and a subtract in the next cycle, then the set row is read from the tag and
// state memories, and a miss runs the remainder unit to pick the victim before
// the write-back. After reset the state memory is cleared one set per cycle,
// with busy high; configuration writes are taken throughout.
// The result strobe cannot be stalled; a new request may start in its cycle.
module two_cache_mesi_coherence_core #(
    parameter int MAX_SETS   = tcmesi_pkg::MAX_SETS_DEF,
    parameter int WAYS       = tcmesi_pkg::WAYS_DEF,
    parameter int ADDR_WIDTH = tcmesi_pkg::ADDR_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tcmesi_pkg::req_t                   request,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcmesi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcmesi_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                               done,
    output tcmesi_pkg::res_t                   result
);

    localparam int TAG_W = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam logic [31:0] AMASK = 32'((64'd1 << TAG_W) - 64'd1);
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(WAYS + 1);
    localparam int RW    = tcmesi_pkg::REM_W;
    // Rounded-up reciprocal of MAX_SETS scaled by 2^32; exact for 15-bit sets.
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SMOD  = 6'b000100,
        S_LOOK  = 6'b001000,
        S_VMOD  = 6'b010000,
        S_WRITE = 6'b100000
    } fsm_t;

    typedef logic [1:0][WAYS-1:0][1:0]       st_row_t;
    typedef logic [1:0][WAYS-1:0][TAG_W-1:0] tag_row_t;

    st_row_t  st_mem  [MAX_SETS];
    tag_row_t tag_mem [MAX_SETS];
    st_row_t  st_rd_reg;
    tag_row_t tag_rd_reg;

    fsm_t              state_reg;
    logic [SET_W-1:0]  clr_reg;
    logic              cmd_reg;
    logic              me_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  set_reg;
    logic [RW-1:0]     set_raw_reg;
    logic [RW-1:0]     quot_reg;
    logic [15:0]       lfsr_reg;
    logic              coh_reg;
    logic [4:0]        offset_reg;
    logic [3:0]        index_reg;
    logic [3:0]        ways_reg;
    logic [31:0]       hit_cnt_reg  [2];
    logic [31:0]       miss_cnt_reg [2];
    logic              done_reg;
    tcmesi_pkg::res_t  result_reg;

    logic              hit_reg;
    logic [WAY_W-1:0]  mw_reg;
    logic              pw_v_reg;
    logic [WAY_W-1:0]  pw_reg;
    logic [WAYS-1:0]   ptm_reg;
    logic [WAYS-1:0]   inv_reg;
    logic              jz_reg;
    logic [CNT_W-1:0]  rank_reg [WAYS];

    logic              accept;
    logic [31:0]       addr_m;
    logic [5:0]        shamt;
    logic [TAG_W-1:0]  tag_in;
    logic [15:0]       set_mask;
    logic [RW-1:0]     set_raw;
    logic [48:0]       set_prod;
    logic [RW-1:0]     quot_in;
    logic [RW-1:0]     set_full;
    logic [SET_W-1:0]  set_idx;

    logic              rem_start;
    logic [RW-1:0]     rem_dividend;
    logic [RW-1:0]     rem_divisor;
    logic              rem_done;
    logic [RW-1:0]     rem_q;

    logic [CNT_W-1:0]  nw;
    logic [4:0]        wiu5;
    logic [WAYS-1:0]   me_m;
    logic [WAYS-1:0]   pv_m;
    logic [WAYS-1:0]   ptm;
    logic [WAYS-1:0]   inv;
    logic [WAY_W-1:0]  mw;
    logic [WAY_W-1:0]  pw;
    logic [CNT_W-1:0]  j_cnt;
    logic [CNT_W-1:0]  rank [WAYS];
    logic [15:0]       lfsr_next;

    logic [WAYS-1:0]   victim_vec;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  way;
    logic [1:0]        fill_st;
    logic [WAYS-1:0][1:0] nme;
    logic [WAYS-1:0][1:0] npe;
    st_row_t           st_wdata;
    tag_row_t          tag_wdata;
    logic [1:0]        peer_out;
    logic [31:0]       hit_cnt_next;
    logic [31:0]       miss_cnt_next;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    // Address split of the incoming request.
    always_comb
    begin
        addr_m   = request.address & AMASK;
        shamt    = {1'b0, offset_reg} + {2'b00, index_reg};
        tag_in   = TAG_W'(addr_m >> shamt);
        set_mask = ~(16'hFFFF << index_reg);
        set_raw  = RW'(addr_m >> offset_reg) & set_mask;
        set_prod = 49'(set_raw) * 49'(RECIP);
        quot_in  = set_prod[47:32];
    end

    assign set_full = set_raw_reg - RW'(quot_reg * RW'(MAX_SETS));
    assign set_idx  = SET_W'(set_full);

    always_comb
    begin
        lfsr_next = {1'b0, lfsr_reg[15:1]};
        if (lfsr_reg[0])
        begin
            lfsr_next = lfsr_next ^ tcmesi_pkg::LFSR_TAPS;
        end
        if (lfsr_next == 16'd0)
        begin
            lfsr_next = 16'd1;
        end
    end

    // Search of the set row once it is back from memory.
    always_comb
    begin
        wiu5 = {1'b0, ways_reg};
        if (wiu5 == 5'd0)
        begin
            nw = CNT_W'(1);
        end
        else if (wiu5 > 5'(WAYS))
        begin
            nw = CNT_W'(WAYS);
        end
        else
        begin
            nw = CNT_W'(wiu5);
        end
        for (int i = 0; i < WAYS; i++)
        begin
            me_m[i] = (CNT_W'(i) < nw) && (st_rd_reg[me_reg][i] != tcmesi_pkg::LS_I)
                      && (tag_rd_reg[me_reg][i] == tag_reg);
            pv_m[i] = (CNT_W'(i) < nw) && (st_rd_reg[!me_reg][i] != tcmesi_pkg::LS_I)
                      && (tag_rd_reg[!me_reg][i] == tag_reg);
            ptm[i]  = (CNT_W'(i) < nw) && (tag_rd_reg[!me_reg][i] == tag_reg);
            inv[i]  = (CNT_W'(i) < nw) && (st_rd_reg[me_reg][i] == tcmesi_pkg::LS_I);
        end
        mw = '0;
        pw = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (me_m[i])
            begin
                mw = WAY_W'(i);
            end
            if (pv_m[i])
            begin
                pw = WAY_W'(i);
            end
        end
        // Rank of each invalid way among the invalid ways below it.
        for (int i = 0; i < WAYS; i++)
        begin
            rank[i] = '0;
            for (int k = 0; k < i; k++)
            begin
                rank[i] = rank[i] + CNT_W'(inv[k]);
            end
        end
        j_cnt = rank[WAYS-1] + CNT_W'(inv[WAYS-1]);
    end

    always_comb
    begin
        rem_start    = (state_reg == S_LOOK) && !(|me_m);
        rem_dividend = lfsr_next;
        rem_divisor  = (j_cnt == '0) ? RW'(nw) : RW'(j_cnt);
    end

    tcmesi_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .done      (rem_done),
        .remainder (rem_q)
    );

    // Write-back row and the result of the access.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (jz_reg)
            begin
                victim_vec[i] = (RW'(i) == rem_q);
            end
            else
            begin
                victim_vec[i] = inv_reg[i] && (RW'(rank_reg[i]) == rem_q);
            end
        end
        victim = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (victim_vec[i])
            begin
                victim = victim | WAY_W'(i);
            end
        end
        way = hit_reg ? mw_reg : victim;

        if (!coh_reg)
        begin
            fill_st = tcmesi_pkg::LS_E;
        end
        else if (!cmd_reg)
        begin
            fill_st = pw_v_reg ? tcmesi_pkg::LS_S : tcmesi_pkg::LS_E;
        end
        else
        begin
            fill_st = tcmesi_pkg::LS_M;
        end

        nme = st_rd_reg[me_reg];
        npe = st_rd_reg[!me_reg];
        if (!hit_reg)
        begin
            nme[way] = fill_st;
        end
        else if (coh_reg && cmd_reg)
        begin
            nme[way] = tcmesi_pkg::LS_M;
        end
        if (coh_reg && !cmd_reg && !hit_reg && pw_v_reg)
        begin
            npe[pw_reg] = tcmesi_pkg::LS_S;
        end
        if (coh_reg && cmd_reg)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (ptm_reg[i])
                begin
                    npe[i] = tcmesi_pkg::LS_I;
                end
            end
        end

        st_wdata          = st_rd_reg;
        st_wdata[me_reg]  = nme;
        st_wdata[!me_reg] = npe;
        tag_wdata         = tag_rd_reg;
        tag_wdata[me_reg][way] = tag_reg;

        peer_out = tcmesi_pkg::LS_I;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (ptm_reg[i] && npe[i] != tcmesi_pkg::LS_I)
            begin
                peer_out = npe[i];
            end
        end

        hit_cnt_next  = hit_cnt_reg[me_reg] + 32'(hit_reg);
        miss_cnt_next = miss_cnt_reg[me_reg] + 32'(!hit_reg);
    end

    // Memories: one row per set holds both caches.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SMOD)
        begin
            st_rd_reg  <= st_mem[set_idx];
            tag_rd_reg <= tag_mem[set_idx];
        end
        if (state_reg == S_CLEAR)
        begin
            st_mem[clr_reg] <= '0;
        end
        else if (state_reg == S_WRITE)
        begin
            st_mem[set_reg] <= st_wdata;
        end
        if (state_reg == S_WRITE && !hit_reg)
        begin
            tag_mem[set_reg] <= tag_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= request.command;
            me_reg      <= request.requester;
            tag_reg     <= tag_in;
            set_raw_reg <= set_raw;
            quot_reg    <= quot_in;
        end
        if (state_reg == S_SMOD)
        begin
            set_reg <= set_idx;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg  <= |me_m;
            mw_reg   <= mw;
            pw_v_reg <= |pv_m;
            pw_reg   <= pw;
            ptm_reg  <= ptm;
            inv_reg  <= inv;
            jz_reg   <= (j_cnt == '0);
            rank_reg <= rank;
        end
        if (state_reg == S_WRITE)
        begin
            result_reg.hit             <= hit_reg;
            result_reg.requester_state <= nme[way];
            result_reg.peer_state      <= peer_out;
            result_reg.way_used        <= 3'(way);
            result_reg.hit_count       <= hit_cnt_next;
            result_reg.miss_count      <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            done_reg        <= 1'b0;
            lfsr_reg        <= tcmesi_pkg::SEED_RST;
            coh_reg         <= tcmesi_pkg::COHERENT_RST;
            offset_reg      <= tcmesi_pkg::OFFSET_RST;
            index_reg       <= tcmesi_pkg::INDEX_RST;
            ways_reg        <= tcmesi_pkg::WAYS_RST;
            hit_cnt_reg[0]  <= '0;
            hit_cnt_reg[1]  <= '0;
            miss_cnt_reg[0] <= '0;
            miss_cnt_reg[1] <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (tcmesi_pkg::cfg_idx_t'(cfg_index))
                    tcmesi_pkg::CFG_COHERENT: coh_reg    <= cfg_data[0];
                    tcmesi_pkg::CFG_OFFSET:   offset_reg <= cfg_data[4:0];
                    tcmesi_pkg::CFG_INDEX:    index_reg  <= cfg_data[3:0];
                    tcmesi_pkg::CFG_WAYS:     ways_reg   <= cfg_data[3:0];
                    tcmesi_pkg::CFG_SEED:
                    begin
                        lfsr_reg <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SET_W'(1);
                    if (clr_reg == SET_W'(MAX_SETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SMOD;
                    end
                end
                S_SMOD:
                begin
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    if (|me_m)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        lfsr_reg  <= lfsr_next;
                        state_reg <= S_VMOD;
                    end
                end
                S_VMOD:
                begin
                    if (rem_done)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    hit_cnt_reg[me_reg]  <= hit_cnt_next;
                    miss_cnt_reg[me_reg] <= miss_cnt_next;
                    done_reg             <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    as_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_WRITE))
        else $error("result strobe without a write-back");

    as_busy_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("request could be taken during the clearing pass");

    as_line_present: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.requester_state != tcmesi_pkg::LS_I))
        else $error("requester line invalid after access");

    as_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && !hit_reg) |-> $onehot(victim_vec))
        else $error("fill victim is not a single way");

endmodule

/* sim/tb.sv */
module tb;

    localparam int NSETS = tcmesi_pkg::MAX_SETS_DEF;
    localparam int NWAYS = tcmesi_pkg::WAYS_DEF;
    localparam int RANDOM_REQUESTS = 650;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    tcmesi_pkg::req_t request;
    logic cfg_valid;
    logic cfg_ready;
    logic [tcmesi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tcmesi_pkg::CFG_DATA_W-1:0] cfg_data;
    logic done;
    tcmesi_pkg::res_t result;

    two_cache_mesi_coherence_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .result(result)
    );

    // Shadow copy of both caches and the block's configuration.
    logic [31:0] shadow_tag [2][NSETS][NWAYS];
    tcmesi_pkg::line_st_t shadow_state [2][NSETS][NWAYS];
    logic [31:0] shadow_hits [2];
    logic [31:0] shadow_misses [2];
    logic [15:0] shadow_lfsr;
    logic mode_coherent;
    logic [4:0] mode_offset;
    logic [3:0] mode_index;
    logic [3:0] mode_ways;

    tcmesi_pkg::res_t pending_results [$];
    int errors;
    longint cycles;
    bit recent_tags_valid;
    logic [31:0] recent_addrs [8];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int way_count();
        int w;
        w = mode_ways;
        if (w == 0) w = 1;
        if (w > NWAYS) w = NWAYS;
        return w;
    endfunction

    function automatic int lookup(int c, int s, logic [31:0] t, int nw);
        for (int i = 0; i < nw; i++)
            if (shadow_state[c][s][i] != tcmesi_pkg::LS_I && shadow_tag[c][s][i] == t)
                return i;
        return -1;
    endfunction

    function automatic int choose_victim(int c, int s, int nw);
        int free_ways [NWAYS];
        int j;
        logic [15:0] r;
        j = 0;
        r = shadow_lfsr >> 1;
        if (shadow_lfsr[0]) r = r ^ tcmesi_pkg::LFSR_TAPS;
        if (r == 0) r = 1;
        shadow_lfsr = r;
        for (int i = 0; i < nw; i++)
            if (shadow_state[c][s][i] == tcmesi_pkg::LS_I)
            begin
                free_ways[j] = i;
                j++;
            end
        if (j == 0) return r % nw;
        return free_ways[r % j];
    endfunction

    function automatic tcmesi_pkg::res_t coherence_access(tcmesi_pkg::req_t rq);
        tcmesi_pkg::res_t r;
        int me;
        int peer;
        int nw;
        int sh;
        int s;
        int mw;
        int pw;
        int w;
        logic [31:0] t;
        logic [63:0] a;
        bit h;
        me = rq.requester;
        peer = 1 - me;
        nw = way_count();
        sh = mode_offset + mode_index;
        a = {32'd0, rq.address};
        t = (sh >= 64) ? 32'd0 : 32'(a >> sh);
        s = int'((a >> mode_offset) & ((64'd1 << mode_index) - 1)) % NSETS;
        mw = lookup(me, s, t, nw);
        pw = lookup(peer, s, t, nw);
        h = (mw >= 0);
        if (h) w = mw;
        else
        begin
            w = choose_victim(me, s, nw);
            shadow_tag[me][s][w] = t;
            if (!mode_coherent) shadow_state[me][s][w] = tcmesi_pkg::LS_E;
            else if (rq.command) shadow_state[me][s][w] = tcmesi_pkg::LS_M;
            else if (pw >= 0) shadow_state[me][s][w] = tcmesi_pkg::LS_S;
            else shadow_state[me][s][w] = tcmesi_pkg::LS_E;
        end
        if (mode_coherent)
        begin
            if (rq.command)
            begin
                shadow_state[me][s][w] = tcmesi_pkg::LS_M;
                for (int i = 0; i < nw; i++)
                    if (shadow_tag[peer][s][i] == t)
                        shadow_state[peer][s][i] = tcmesi_pkg::LS_I;
            end
            else if (!h && pw >= 0) shadow_state[peer][s][pw] = tcmesi_pkg::LS_S;
        end
        if (h) shadow_hits[me]++;
        else shadow_misses[me]++;
        pw = lookup(peer, s, t, nw);
        r.hit = h;
        r.requester_state = shadow_state[me][s][w];
        r.peer_state = (pw >= 0) ? shadow_state[peer][s][pw] : tcmesi_pkg::LS_I;
        r.way_used = w[2:0];
        r.hit_count = shadow_hits[me];
        r.miss_count = shadow_misses[me];
        return r;
    endfunction

    task automatic write_register(tcmesi_pkg::cfg_idx_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tcmesi_pkg::CFG_COHERENT: mode_coherent = value[0];
            tcmesi_pkg::CFG_OFFSET: mode_offset = value[4:0];
            tcmesi_pkg::CFG_INDEX: mode_index = value[3:0];
            tcmesi_pkg::CFG_WAYS: mode_ways = value[3:0];
            tcmesi_pkg::CFG_SEED: shadow_lfsr = (value == 0) ? 16'd1 : value;
            default: ;
        endcase
    endtask

    // Drive one request; an expectation given with has_fixed replaces the prediction.
    // With no gap, start stays high into the next request.
    task automatic issue_access(tcmesi_pkg::req_t rq, bit has_fixed,
                                tcmesi_pkg::res_t fixed);
        tcmesi_pkg::res_t predicted;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        predicted = coherence_access(rq);
        pending_results.push_back(has_fixed ? fixed : predicted);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                tcmesi_pkg::res_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.hit !== exp_r.hit || result.requester_state !== exp_r.requester_state
                    || result.peer_state !== exp_r.peer_state
                    || result.way_used !== exp_r.way_used
                    || result.hit_count !== exp_r.hit_count
                    || result.miss_count !== exp_r.miss_count)
                begin
                    $display("%0t mismatch: expected %p actual %p", $time, exp_r, result);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        tcmesi_pkg::req_t rq;
        bit fixed;
        tcmesi_pkg::res_t res;
    } directed_row_t;

    function automatic tcmesi_pkg::req_t make_request(logic cmd, logic who,
                                                      logic [31:0] addr);
        tcmesi_pkg::req_t rq;
        rq.command = cmd;
        rq.requester = who;
        rq.address = addr;
        return rq;
    endfunction

    function automatic logic [31:0] random_address();
        if (recent_tags_valid && $urandom_range(0, 3) != 0)
            return recent_addrs[$urandom_range(0, 7)] ^ $urandom_range(0, 31);
        return $urandom();
    endfunction

    task automatic random_phase(int count, int pool_span);
        for (int i = 0; i < 8; i++)
            recent_addrs[i] = $urandom() & ~(32'hFFFFFFFF >> pool_span);
        recent_tags_valid = 1'b1;
        for (int n = 0; n < count; n++)
            issue_access(make_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                random_address()), 1'b0, '0);
    endtask

    initial
    begin
        directed_row_t rows [$];
        tcmesi_pkg::res_t fx;
        errors = 0;
        cycles = 0;
        recent_tags_valid = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = tcmesi_pkg::CFG_COHERENT;
        cfg_data = '0;
        for (int c = 0; c < 2; c++)
        begin
            shadow_hits[c] = 0;
            shadow_misses[c] = 0;
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++)
                begin
                    shadow_tag[c][s][w] = 0;
                    shadow_state[c][s][w] = tcmesi_pkg::LS_I;
                end
        end
        mode_coherent = tcmesi_pkg::COHERENT_RST;
        mode_offset = tcmesi_pkg::OFFSET_RST;
        mode_index = tcmesi_pkg::INDEX_RST;
        mode_ways = tcmesi_pkg::WAYS_RST;
        shadow_lfsr = tcmesi_pkg::SEED_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // First access after reset: a read miss filling as Exclusive in way 0 or a free way.
        fx = '0;
        rows.push_back('{make_request(1'b0, 1'b0, 32'h0000_0000), 1'b0, fx});
        fx.hit = 1'b1; fx.requester_state = tcmesi_pkg::LS_E; fx.way_used = 3'd0;
        fx.hit_count = 32'd1; fx.miss_count = 32'd1;
        rows.push_back('{make_request(1'b0, 1'b0, 32'h0000_0000), 1'b1, fx});
        rows.push_back('{make_request(1'b0, 1'b1, 32'h0000_001F), 1'b0, fx});
        rows.push_back('{make_request(1'b1, 1'b1, 32'h0000_0000), 1'b0, fx});
        rows.push_back('{make_request(1'b1, 1'b0, 32'h0000_0004), 1'b0, fx});
        rows.push_back('{make_request(1'b0, 1'b1, 32'hFFFF_FFFF), 1'b0, fx});
        rows.push_back('{make_request(1'b1, 1'b0, 32'hFFFF_FFFF), 1'b0, fx});
        rows.push_back('{make_request(1'b0, 1'b1, 32'hFFFF_FFE0), 1'b0, fx});
        rows.push_back('{make_request(1'b1, 1'b1, 32'hFFFF_FFE0), 1'b0, fx});
        for (int k = 0; k < 10; k++)
            rows.push_back('{make_request(k[0], 1'b0, 32'h0001_0000 * k), 1'b0, fx});
        foreach (rows[i])
            issue_access(rows[i].rq, rows[i].fixed, rows[i].res);
        drain();

        random_phase(150, 6);
        drain();

        // Coherence off, tiny geometry, odd seed.
        write_register(tcmesi_pkg::CFG_COHERENT, 16'd0);
        write_register(tcmesi_pkg::CFG_WAYS, 16'd1);
        write_register(tcmesi_pkg::CFG_INDEX, 16'd0);
        write_register(tcmesi_pkg::CFG_OFFSET, 16'd0);
        write_register(tcmesi_pkg::CFG_SEED, 16'd0);
        random_phase(100, 4);
        drain();

        // Offset 16 plus index 15 leaves only address bit 31 as the tag; 15 ways clamp to the cache's ways.
        write_register(tcmesi_pkg::CFG_COHERENT, 16'd1);
        write_register(tcmesi_pkg::CFG_OFFSET, 16'd16);
        write_register(tcmesi_pkg::CFG_INDEX, 16'd15);
        write_register(tcmesi_pkg::CFG_WAYS, 16'd15);
        write_register(tcmesi_pkg::CFG_SEED, 16'hFFFF);
        random_phase(100, 10);
        drain();

        write_register(tcmesi_pkg::CFG_OFFSET, 16'd31);
        write_register(tcmesi_pkg::CFG_INDEX, 16'd2);
        write_register(tcmesi_pkg::CFG_WAYS, 16'd0);
        random_phase(60, 8);
        drain();

        write_register(tcmesi_pkg::CFG_OFFSET, 16'd2);
        write_register(tcmesi_pkg::CFG_INDEX, 16'd3);
        write_register(tcmesi_pkg::CFG_WAYS, 16'd4);
        write_register(tcmesi_pkg::CFG_SEED, 16'hACE1);
        random_phase(140, 3);
        drain();

        write_register(tcmesi_pkg::CFG_COHERENT, 16'd0);
        write_register(tcmesi_pkg::CFG_OFFSET, 16'd5);
        write_register(tcmesi_pkg::CFG_INDEX, 16'd8);
        write_register(tcmesi_pkg::CFG_WAYS, 16'd8);
        random_phase(100, 12);
        drain();

        if (errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
